[rtl/s2l_pkg.sv]
// Package for the solar-to-lunar date converter: shared types, constants
// and constant tables (Gregorian month data, lunar year lengths, month codes).
// No dependencies.
package s2l_pkg;

  localparam int TABLE_YEARS = 50;
  localparam int ROWS_HELD   = 50;
  localparam int NYEARS      = (TABLE_YEARS < ROWS_HELD) ? TABLE_YEARS : ROWS_HELD;
  localparam int DaysW       = 16;
  localparam logic [DaysW-1:0] BASIS_DAY  = 16'd24;
  localparam logic [DaysW-1:0] DAYS_YEAR  = 16'd365;
  localparam logic [DaysW-1:0] DAY_LIMIT  = 16'd30;
  localparam logic [3:0]       LAST_MONTH = 4'd11;

  typedef logic [0:11][2:0] month_row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } s2l_state_e;

  typedef struct packed {
    logic load;
    logic calc;
    logic fail;
    logic year_step;
    logic month_step;
    logic out_load;
  } s2l_cmd_t;

  typedef struct packed {
    logic ok;
    logic yi_end;
    logic yr_fit;
    logic mo_fit;
    logic mi_last;
  } s2l_sts_t;

  function automatic logic is_leap(input logic [6:0] off);
    is_leap = (off[1:0] == 2'b00) && (off != 7'd100);
  endfunction

  function automatic logic [4:0] greg_days(input logic [3:0] m);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: greg_days = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    greg_days = 5'd30;
      4'd2:                                       greg_days = 5'd28;
      default:                                    greg_days = 5'd0;
    endcase
  endfunction

  function automatic logic [8:0] cum_days(input logic [3:0] m);
    case (m)
      4'd2:    cum_days = 9'd31;
      4'd3:    cum_days = 9'd59;
      4'd4:    cum_days = 9'd90;
      4'd5:    cum_days = 9'd120;
      4'd6:    cum_days = 9'd151;
      4'd7:    cum_days = 9'd181;
      4'd8:    cum_days = 9'd212;
      4'd9:    cum_days = 9'd243;
      4'd10:   cum_days = 9'd273;
      4'd11:   cum_days = 9'd304;
      4'd12:   cum_days = 9'd334;
      default: cum_days = 9'd0;
    endcase
  endfunction

  function automatic logic [5:0] month_len(input logic [2:0] code);
    case (code)
      3'd0:    month_len = 6'd29;
      3'd1:    month_len = 6'd30;
      3'd2:    month_len = 6'd58;
      3'd3:    month_len = 6'd59;
      3'd4:    month_len = 6'd59;
      3'd5:    month_len = 6'd60;
      default: month_len = 6'd29;
    endcase
  endfunction

  function automatic logic [4:0] month_part(input logic [2:0] code);
    case (code)
      3'd2:             month_part = 5'd29;
      3'd3, 3'd4, 3'd5: month_part = 5'd30;
      default:          month_part = 5'd0;
    endcase
  endfunction

  function automatic logic [8:0] year_len(input logic [5:0] yi);
    case (yi)
      6'd0:  year_len = 9'd384;  6'd1:  year_len = 9'd354;
      6'd2:  year_len = 9'd355;  6'd3:  year_len = 9'd384;
      6'd4:  year_len = 9'd354;  6'd5:  year_len = 9'd385;
      6'd6:  year_len = 9'd354;  6'd7:  year_len = 9'd354;
      6'd8:  year_len = 9'd384;  6'd9:  year_len = 9'd354;
      6'd10: year_len = 9'd354;  6'd11: year_len = 9'd384;
      6'd12: year_len = 9'd355;  6'd13: year_len = 9'd384;
      6'd14: year_len = 9'd355;  6'd15: year_len = 9'd354;
      6'd16: year_len = 9'd384;  6'd17: year_len = 9'd354;
      6'd18: year_len = 9'd354;  6'd19: year_len = 9'd384;
      6'd20: year_len = 9'd354;  6'd21: year_len = 9'd355;
      6'd22: year_len = 9'd384;  6'd23: year_len = 9'd354;
      6'd24: year_len = 9'd384;  6'd25: year_len = 9'd355;
      6'd26: year_len = 9'd354;  6'd27: year_len = 9'd383;
      6'd28: year_len = 9'd355;  6'd29: year_len = 9'd354;
      6'd30: year_len = 9'd384;  6'd31: year_len = 9'd355;
      6'd32: year_len = 9'd384;  6'd33: year_len = 9'd354;
      6'd34: year_len = 9'd354;  6'd35: year_len = 9'd384;
      6'd36: year_len = 9'd354;  6'd37: year_len = 9'd354;
      6'd38: year_len = 9'd384;  6'd39: year_len = 9'd355;
      6'd40: year_len = 9'd355;  6'd41: year_len = 9'd384;
      6'd42: year_len = 9'd354;  6'd43: year_len = 9'd384;
      6'd44: year_len = 9'd354;  6'd45: year_len = 9'd354;
      6'd46: year_len = 9'd384;  6'd47: year_len = 9'd353;
      6'd48: year_len = 9'd355;  6'd49: year_len = 9'd384;
      default: year_len = 9'd0;
    endcase
  endfunction

  // Each octal digit is the length code of one month, first month leftmost.
  function automatic month_row_t month_row(input logic [5:0] yi);
    logic [35:0] r;
    case (yi)
      6'd0:  r = 36'o111210010101;  6'd1:  r = 36'o110101001010;
      6'd2:  r = 36'o110110100101;  6'd3:  r = 36'o041101010101;
      6'd4:  r = 36'o010101101100;  6'd5:  r = 36'o101010411011;
      6'd6:  r = 36'o001001011101;  6'd7:  r = 36'o100100101101;
      6'd8:  r = 36'o110040101011;  6'd9:  r = 36'o101010010101;
      6'd10: r = 36'o101101001010;  6'd11: r = 36'o105101001010;
      6'd12: r = 36'o101101010101;  6'd13: r = 36'o010101014101;
      6'd14: r = 36'o010010111011;  6'd15: r = 36'o001001011011;
      6'd16: r = 36'o100121010111;  6'd17: r = 36'o010100101011;
      6'd18: r = 36'o101010010101;  6'd19: r = 36'o101410010101;
      6'd20: r = 36'o011010101010;  6'd21: r = 36'o101011010101;
      6'd22: r = 36'o041010110101;  6'd23: r = 36'o010010110110;
      6'd24: r = 36'o101004101110;  6'd25: r = 36'o101001010111;
      6'd26: r = 36'o010100100111;  6'd27: r = 36'o011040100110;
      6'd28: r = 36'o110110010011;  6'd29: r = 36'o010110101010;
      6'd30: r = 36'o104101101010;  6'd31: r = 36'o100101101101;
      6'd32: r = 36'o010010411101;  6'd33: r = 36'o010010101110;
      6'd34: r = 36'o101001001101;  6'd35: r = 36'o110103001011;
      6'd36: r = 36'o110100100101;  6'd37: r = 36'o110101010010;
      6'd38: r = 36'o110141010100;  6'd39: r = 36'o101101101010;
      6'd40: r = 36'o100101101101;  6'd41: r = 36'o040101011011;
      6'd42: r = 36'o010010011011;  6'd43: r = 36'o101001210111;
      6'd44: r = 36'o101001001011;  6'd45: r = 36'o101100100101;
      6'd46: r = 36'o101130100101;  6'd47: r = 36'o011011010000;
      6'd48: r = 36'o101011011010;  6'd49: r = 36'o103010110110;
      default: r = 36'o000000000000;
    endcase
    month_row = month_row_t'(r);
  endfunction

endpackage

[rtl/s2l_if.sv]
// Handshake interfaces for the solar-to-lunar date converter: the input date
// channel and the output lunar date channel. No dependencies.
interface s2l_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] solar_year;
  logic [3:0] solar_month;
  logic [4:0] solar_day;

  modport source (output valid, solar_year, solar_month, solar_day, input ready);
  modport sink (input valid, solar_year, solar_month, solar_day, output ready);
endinterface

interface s2l_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] lunar_year;
  logic [3:0] lunar_month;
  logic [4:0] lunar_day;
  logic       in_range;

  modport source (output valid, lunar_year, lunar_month, lunar_day, in_range, input ready);
  modport sink (input valid, lunar_year, lunar_month, lunar_day, in_range, output ready);
endinterface

[rtl/solar_to_lunar_date.sv]
// Solar-to-lunar date converter, top level. Depends on s2l_pkg, s2l_if,
// s2l_ctrl and s2l_datapath.
// An accepted beat passes through the day count, the year walk (one table row
// per cycle) and the month walk (one month per cycle) before its result is loaded
// into the output register. A new date is accepted only in the cycle after the
// previous one has been handed to the output register.
// Reset is asynchronous, active low, and clears the controller and the output valid.
module solar_to_lunar_date
  import s2l_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  s2l_in_if.sink   sol_i,
  s2l_out_if.source lun_o
);

  s2l_cmd_t cmd;
  s2l_sts_t sts;

  s2l_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sol_i.valid),
    .in_ready_o  (sol_i.ready),
    .out_valid_o (lun_o.valid),
    .out_ready_i (lun_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  s2l_datapath u_datapath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .solar_year_i  (sol_i.solar_year),
    .solar_month_i (sol_i.solar_month),
    .solar_day_i   (sol_i.solar_day),
    .lunar_year_o  (lun_o.lunar_year),
    .lunar_month_o (lun_o.lunar_month),
    .lunar_day_o   (lun_o.lunar_day),
    .in_range_o    (lun_o.in_range)
  );

endmodule

[rtl/s2l_datapath.sv]
// Datapath of the solar-to-lunar date converter: day count, year and month
// walks and the output register. Depends on s2l_pkg.
module s2l_datapath
  import s2l_pkg::*;
(
  input  logic       clk_i,
  input  s2l_cmd_t   cmd_i,
  output s2l_sts_t   sts_o,
  input  logic [6:0] solar_year_i,
  input  logic [3:0] solar_month_i,
  input  logic [4:0] solar_day_i,
  output logic [5:0] lunar_year_o,
  output logic [3:0] lunar_month_o,
  output logic [4:0] lunar_day_o,
  output logic       in_range_o
);

  logic [6:0]       y_q;
  logic [3:0]       m_q;
  logic [4:0]       d_q;
  logic [DaysW-1:0] rem_q, rem_d;
  logic [5:0]       yi_q, yi_d;
  logic [3:0]       mi_q, mi_d;
  logic             ok_q, ok_d;
  logic [5:0]       ly_q;
  logic [3:0]       lm_q;
  logic [4:0]       ld_q;
  logic             lr_q;

  logic             leap;
  logic [4:0]       dim;
  logic             date_ok;
  logic [6:0]       y_m1;
  logic [DaysW-1:0] total;
  logic [DaysW-1:0] ylen;
  month_row_t       row;
  logic [2:0]       code;
  logic [DaysW-1:0] mlen;
  logic [DaysW-1:0] mpart;
  logic [DaysW-1:0] r2;
  logic [DaysW-1:0] day;

  always_comb begin
    leap    = is_leap(y_q);
    dim     = ((m_q == 4'd2) && leap) ? 5'd29 : greg_days(m_q);
    date_ok = (y_q != 7'd0) && (m_q != 4'd0) && (m_q <= 4'd12)
              && (d_q != 5'd0) && (d_q <= dim);
    y_m1    = y_q - 7'd1;
    total   = DaysW'(y_m1) * DAYS_YEAR
              + DaysW'(y_m1[6:2]) - DaysW'(y_q > 7'd100)
              + DaysW'(cum_days(m_q))
              + DaysW'((m_q > 4'd2) && leap)
              + DaysW'(d_q);
    ylen    = DaysW'(year_len(yi_q));
    row     = month_row(yi_q);
    code    = row[mi_q];
    mlen    = DaysW'(month_len(code));
    mpart   = DaysW'(month_part(code));
    r2      = (rem_q >= mpart) ? rem_q - mpart : rem_q;
    day     = (r2 + DaysW'(1) > DAY_LIMIT) ? DAY_LIMIT : r2 + DaysW'(1);
  end

  always_comb begin
    rem_d = rem_q;
    yi_d  = yi_q;
    mi_d  = mi_q;
    ok_d  = ok_q;
    if (cmd_i.calc) begin
      rem_d = total - BASIS_DAY;
      yi_d  = 6'd0;
      mi_d  = 4'd0;
      ok_d  = date_ok && (total >= BASIS_DAY);
    end
    if (cmd_i.fail) begin
      ok_d = 1'b0;
    end
    if (cmd_i.year_step) begin
      rem_d = rem_q - ylen;
      yi_d  = yi_q + 6'd1;
    end
    if (cmd_i.month_step) begin
      rem_d = rem_q - mlen;
      mi_d  = mi_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      y_q <= solar_year_i;
      m_q <= solar_month_i;
      d_q <= solar_day_i;
    end
    rem_q <= rem_d;
    yi_q  <= yi_d;
    mi_q  <= mi_d;
    ok_q  <= ok_d;
    if (cmd_i.out_load) begin
      ly_q <= ok_q ? yi_q + 6'd1 : 6'd0;
      lm_q <= ok_q ? mi_q + 4'd1 : 4'd0;
      ld_q <= ok_q ? day[4:0] : 5'd0;
      lr_q <= ok_q;
    end
  end

  assign sts_o.ok      = ok_q;
  assign sts_o.yi_end  = (yi_q == 6'(NYEARS));
  assign sts_o.yr_fit  = (rem_q < ylen);
  assign sts_o.mo_fit  = (rem_q < mlen);
  assign sts_o.mi_last = (mi_q == LAST_MONTH);

  assign lunar_year_o  = ly_q;
  assign lunar_month_o = lm_q;
  assign lunar_day_o   = ld_q;
  assign in_range_o    = lr_q;

endmodule

[rtl/s2l_ctrl.sv]
// Controller of the solar-to-lunar date converter: sequences the day count,
// the year and month walks and the output beat. Depends on s2l_pkg.
module s2l_ctrl
  import s2l_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  s2l_sts_t sts_i,
  output s2l_cmd_t cmd_o
);

  s2l_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_free   = !out_valid_q || out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_YEAR;
      end
      ST_YEAR: begin
        if (!sts_i.ok || sts_i.yi_end) begin
          cmd_o.fail = 1'b1;
          state_d    = ST_DONE;
        end else if (sts_i.yr_fit) begin
          state_d = ST_MONTH;
        end else begin
          cmd_o.year_step = 1'b1;
        end
      end
      ST_MONTH: begin
        if (sts_i.mo_fit || sts_i.mi_last) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.month_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = cmd_o.out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("Result register loaded while a beat is pending.");

  a_year_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.year_step |-> (!sts_i.yi_end && sts_i.ok))
    else $error("Year walk stepped past the table.");

  a_month_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.month_step |-> !sts_i.mi_last)
    else $error("Month walk stepped past the last month.");

  a_calc_then_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |=> (state_q == ST_YEAR))
    else $error("Day count not followed by the year walk.");
`endif

endmodule
